FILE: rtl/tccs_pkg.sv
`timescale 1ns / 1ps

package tccs_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int APB_AW = 3;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = {RESET_COLOR, SPACE_CODE};

  // Byte address of the only configuration register.
  localparam logic [APB_AW-1:0] ADDR_TEXT_COLOR = 3'd0;

  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCR_RD,
    S_SCR_WR,
    S_FILL
  } state_t;

  typedef struct packed {
    action_t          action;
    logic [7:0]       char_code;
    logic [7:0]       cell_color;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    cell_t            cell_word;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             scrolled;
    logic             range_error;
  } res_t;

endpackage

FILE: rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps

// Channel   Signals                          Handshake
// command   start, busy, cmd (cmd_t)         beat when start && !busy
// result    done, res (res_t)                beat when done, one cycle, no stall
// config    psel, penable, pwrite, paddr,    write when psel && penable && pwrite,
//           pwdata, prdata, pready           pready tied high
//
// Put without scroll, direct write and out-of-range access finish in S_IDLE; a read passes
// S_READ; clear fills every cell in S_FILL; a scroll alternates S_SCR_RD and S_SCR_WR per
// copied cell, then blanks the bottom row in S_FILL, as the screen memory has one read and
// one write port (copy is read, then write). After rst, S_INIT clears every cell with busy
// high. Results cannot be stalled; done is high for exactly one cycle per command.

module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd,
  output logic              done,
  output res_t              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FILL_FIRST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  cell_t mem [CELLS];
  cell_t rdata;
  logic  we;
  logic  [ADDR_W-1:0] waddr, raddr;
  cell_t wdata;

  state_t state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [7:0]        text_color;
  cell_t             fill_cell, fill_cell_next;
  cell_t             word, word_next;
  logic              scrolled, scrolled_next;
  logic              rerr, rerr_next;
  logic              done_next;

  logic              accept, on_screen, wrap, is_newline;
  logic [COL_W:0]    col_inc;
  logic [ADDR_W-1:0] cur_addr, pos_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TEXT_COLOR) ? {24'd0, text_color} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && paddr == ADDR_TEXT_COLOR) begin
      text_color <= pwdata[7:0];
    end
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign on_screen  = (int'(cmd.col) < COLUMNS) && (int'(cmd.row) < ROWS);
  assign pos_addr   = ADDR_W'(int'(cmd.row) * COLUMNS) + ADDR_W'(cmd.col);
  assign cur_addr   = ADDR_W'(int'(cur_row) * COLUMNS) + ADDR_W'(cur_col);
  assign col_inc    = {1'b0, cur_col} + (COL_W+1)'(1);
  assign wrap       = (int'(col_inc) >= COLUMNS);
  assign is_newline = (cmd.char_code == NEWLINE_CODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      idx      <= '0;
      cur_col  <= '0;
      cur_row  <= '0;
      done     <= 1'b0;
      scrolled <= 1'b0;
      rerr     <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      cur_col  <= cur_col_next;
      cur_row  <= cur_row_next;
      done     <= done_next;
      scrolled <= scrolled_next;
      rerr     <= rerr_next;
    end
  end

  always_ff @(posedge clk) begin
    fill_cell <= fill_cell_next;
    word      <= word_next;
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    fill_cell_next = fill_cell;
    word_next      = word;
    scrolled_next  = scrolled;
    rerr_next      = rerr;
    done_next      = 1'b0;
    we             = 1'b0;
    waddr          = idx;
    wdata          = fill_cell;
    raddr          = pos_addr;

    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = BLANK_RESET;
        if (idx == LAST_ADDR) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          word_next     = '0;
          scrolled_next = 1'b0;
          rerr_next     = 1'b0;
          done_next     = 1'b1;
          unique case (cmd.action)
            ACT_PUT: begin
              if (!is_newline) begin
                we    = 1'b1;
                waddr = cur_addr;
                wdata = {text_color, cmd.char_code};
              end
              if (is_newline || wrap) begin
                cur_col_next = '0;
                if (cur_row == LAST_ROW) begin
                  // Scroll: copy every row up by one, then blank the bottom row.
                  done_next      = 1'b0;
                  scrolled_next  = 1'b1;
                  fill_cell_next = {text_color, SPACE_CODE};
                  idx_next       = '0;
                  state_next     = S_SCR_RD;
                end else begin
                  cur_row_next = cur_row + ROW_W'(1);
                end
              end else begin
                cur_col_next = col_inc[COL_W-1:0];
              end
            end
            ACT_WRITE: begin
              if (on_screen) begin
                we    = 1'b1;
                waddr = pos_addr;
                wdata = {cmd.cell_color, cmd.char_code};
              end else begin
                rerr_next = 1'b1;
              end
            end
            ACT_CLEAR: begin
              done_next      = 1'b0;
              cur_col_next   = '0;
              cur_row_next   = '0;
              fill_cell_next = {text_color, SPACE_CODE};
              idx_next       = '0;
              state_next     = S_FILL;
            end
            ACT_READ: begin
              if (on_screen) begin
                done_next  = 1'b0;
                state_next = S_READ;
              end else begin
                rerr_next = 1'b1;
              end
            end
            default: begin
              rerr_next = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        word_next  = rdata;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_SCR_RD: begin
        raddr      = idx + ADDR_W'(COLUMNS);
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata;
        if (idx == COPY_LAST) begin
          idx_next   = FILL_FIRST;
          state_next = S_FILL;
        end else begin
          idx_next   = idx + ADDR_W'(1);
          state_next = S_SCR_RD;
        end
      end
      S_FILL: begin
        we = 1'b1;
        if (idx == LAST_ADDR) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.cell_word   = word;
  assign res.cursor_col  = cur_col;
  assign res.cursor_row  = cur_row;
  assign res.scrolled    = scrolled;
  assign res.range_error = rerr;

endmodule

FILE: rtl/tccs_checker.sv
`timescale 1ns / 1ps

module tccs_checker
  import tccs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input res_t res
);

  // Every accepted command either finishes in the next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted command neither finished nor held busy");

  // A result beat only follows an accepted command or a busy period.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy) || $past(busy))
    else $error("result beat without a command");

  // The reported cursor always lies on the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    done |-> (int'(res.cursor_col) < COLUMNS) && (int'(res.cursor_row) < ROWS))
    else $error("cursor off screen");

  // A scroll always leaves the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    done && res.scrolled |-> res.cursor_col == '0 && int'(res.cursor_row) == ROWS - 1)
    else $error("scroll left cursor elsewhere");

  // A range error never comes with read data.
  a_rerr_no_data: assert property (@(posedge clk) disable iff (rst)
    done && res.range_error |-> res.cell_word == '0 && !res.scrolled)
    else $error("range error with data or scroll");

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tccs_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .res  (res)
);

FILE: tb/sv/tb_text_console_cursor_scroll.sv
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll;
  import tccs_pkg::*;

  localparam int SCR_COLS      = 80;
  localparam int SCR_ROWS      = 25;
  localparam int SCR_CELLS     = SCR_COLS * SCR_ROWS;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 314;
  localparam int CALM_TAIL     = 300;
  // A scroll and a clear each run over the whole screen memory, so both are rationed.
  localparam int SCROLL_BUDGET = 180;
  localparam int CLEAR_BUDGET  = 50;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
    int   new_color;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  cmd_t              cmd;
  logic              done;
  res_t              res;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  cell_t            screen_mirror [SCR_CELLS];
  logic [COL_W-1:0] cursor_col_m;
  logic [ROW_W-1:0] cursor_row_m;
  logic [7:0]       color_m;
  int               scrolls_seen;
  int               clears_seen;
  int               mismatches;
  res_t             due_reports [$];
  bit               idling_on;

  text_console_cursor_scroll #(
    .COLUMNS(SCR_COLS),
    .ROWS   (SCR_ROWS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .res    (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Cursor to the start of the next line; on the bottom row the screen moves up.
  function automatic bit next_line();
    cursor_col_m = '0;
    if (int'(cursor_row_m) == SCR_ROWS - 1) begin
      for (int i = 0; i < SCR_COLS * (SCR_ROWS - 1); i++)
        screen_mirror[i] = screen_mirror[i + SCR_COLS];
      for (int i = SCR_COLS * (SCR_ROWS - 1); i < SCR_CELLS; i++)
        screen_mirror[i] = {color_m, SPACE_CODE};
      scrolls_seen++;
      return 1'b1;
    end
    cursor_row_m = cursor_row_m + 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t advance_console(input cmd_t c);
    res_t r;
    bit   on_screen;
    int   idx;
    r = '0;
    on_screen = (int'(c.col) < SCR_COLS) && (int'(c.row) < SCR_ROWS);
    idx = int'(c.row) * SCR_COLS + int'(c.col);
    case (c.action)
      ACT_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          r.scrolled = next_line();
        end else begin
          screen_mirror[int'(cursor_row_m) * SCR_COLS + int'(cursor_col_m)] =
            {color_m, c.char_code};
          cursor_col_m = cursor_col_m + 1'b1;
          if (int'(cursor_col_m) >= SCR_COLS)
            r.scrolled = next_line();
        end
      end
      ACT_WRITE: begin
        if (on_screen)
          screen_mirror[idx] = {c.cell_color, c.char_code};
        else
          r.range_error = 1'b1;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SCR_CELLS; i++)
          screen_mirror[i] = {color_m, SPACE_CODE};
        cursor_col_m = '0;
        cursor_row_m = '0;
        clears_seen++;
      end
      default: begin
        if (on_screen)
          r.cell_word = screen_mirror[idx];
        else
          r.range_error = 1'b1;
      end
    endcase
    r.cursor_col = cursor_col_m;
    r.cursor_row = cursor_row_m;
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input action_t a, input logic [7:0] ch,
                                  input logic [7:0] color, input int col, input int row);
    cmd_t c;
    c.action     = a;
    c.char_code  = ch;
    c.cell_color = color;
    c.col        = COL_W'(col);
    c.row        = ROW_W'(row);
    return c;
  endfunction

  function automatic res_t mk_res(input cell_t word, input int col, input int row,
                                  input logic scr, input logic err);
    res_t r;
    r.cell_word   = word;
    r.cursor_col  = COL_W'(col);
    r.cursor_row  = ROW_W'(row);
    r.scrolled    = scr;
    r.range_error = err;
    return r;
  endfunction

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (idling_on && $urandom_range(0, 5) == 0)
      pause_sender($urandom_range(1, 17));
  endtask

  task automatic issue(input cmd_t c, input bit typed, input res_t typed_res);
    res_t predicted;
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = advance_console(c);
    due_reports.push_back(typed ? typed_res : predicted);
  endtask

  // The register only changes once the block has drained every command.
  task automatic set_text_color(input logic [7:0] value);
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TEXT_COLOR;
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    color_m = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: word %h col %0d row %0d scrolled %b range_error %b",
                   res.cell_word, res.cursor_col, res.cursor_row, res.scrolled,
                   res.range_error);
      end else begin
        want = due_reports.pop_front();
        if (res.cell_word !== want.cell_word || res.cursor_col !== want.cursor_col ||
            res.cursor_row !== want.cursor_row || res.scrolled !== want.scrolled ||
            res.range_error !== want.range_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected word %h col %0d row %0d scr %b err %b, got word %h col %0d row %0d scr %b err %b",
                     $realtime, want.cell_word, want.cursor_col, want.cursor_row,
                     want.scrolled, want.range_error, res.cell_word, res.cursor_col,
                     res.cursor_row, res.scrolled, res.range_error);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    dir_row_t   directed [$];
    logic [7:0] phase_colors [PHASES];
    cmd_t       c;
    int         items_sent;
    int         sent;
    int         mode;
    int         burst;
    int         nl_odds;
    int         last_col;
    int         last_row;

    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    scrolls_seen = 0;
    clears_seen  = 0;
    idling_on    = 1'b1;
    color_m      = RESET_COLOR;
    cursor_col_m = '0;
    cursor_row_m = '0;
    for (int i = 0; i < SCR_CELLS; i++)
      screen_mirror[i] = BLANK_RESET;

    // Rows with a typed result can be read straight off the screen contents.
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h0720, 0, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 79, 24), 1'b1,
                         mk_res(16'h0720, 0, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'hFF, 8'hFF, 127, 31), 1'b1,
                         mk_res(16'h0000, 0, 0, 0, 1), -1});
    directed.push_back('{mk_cmd(ACT_WRITE, 8'h55, 8'h12, 80, 0), 1'b1,
                         mk_res(16'h0000, 0, 0, 0, 1), -1});
    directed.push_back('{mk_cmd(ACT_WRITE, 8'h55, 8'h12, 0, 25), 1'b1,
                         mk_res(16'h0000, 0, 0, 0, 1), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 0, 24), 1'b1,
                         mk_res(16'h0720, 0, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_WRITE, 8'hFF, 8'hFF, 79, 24), 1'b1,
                         mk_res(16'h0000, 0, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 79, 24), 1'b1,
                         mk_res(16'hFFFF, 0, 0, 0, 0), -1});
    // A newline byte through a direct write is stored like any other character.
    directed.push_back('{mk_cmd(ACT_WRITE, NEWLINE_CODE, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h0000, 0, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h000A, 0, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_PUT, 8'h41, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h0000, 1, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_PUT, 8'h00, 8'hFF, 127, 31), 1'b1,
                         mk_res(16'h0000, 2, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_PUT, 8'hFF, 8'h00, 0, 0), 1'b0, '0, -1});
    directed.push_back('{mk_cmd(ACT_PUT, NEWLINE_CODE, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h0000, 0, 1, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h0741, 0, 1, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 1, 0), 1'b1,
                         mk_res(16'h0700, 0, 1, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 2, 0), 1'b0, '0, -1});
    directed.push_back('{mk_cmd(ACT_CLEAR, 8'h00, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h0000, 0, 0, 0, 0), 8'hFF});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 79, 24), 1'b1,
                         mk_res(16'hFF20, 0, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_PUT, SPACE_CODE, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h0000, 1, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_WRITE, 8'h7E, 8'h3C, 64, 16), 1'b0, '0, 8'h00});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 64, 16), 1'b0, '0, -1});
    directed.push_back('{mk_cmd(ACT_CLEAR, 8'h00, 8'h00, 0, 0), 1'b1,
                         mk_res(16'h0000, 0, 0, 0, 0), -1});
    directed.push_back('{mk_cmd(ACT_READ, 8'h00, 8'h00, 40, 12), 1'b1,
                         mk_res(16'h0020, 0, 0, 0, 0), -1});

    phase_colors[0] = 8'h00;
    phase_colors[1] = 8'hFF;
    phase_colors[2] = 8'($urandom);
    phase_colors[3] = 8'h0F;
    phase_colors[4] = 8'($urandom);
    phase_colors[5] = 8'hF0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The power-up clearing pass must finish before the register is touched.
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].new_color >= 0)
        set_text_color(8'(directed[i].new_color));
      maybe_pause();
      issue(directed[i].c, directed[i].typed, directed[i].r);
    end

    items_sent = 0;
    last_col   = 0;
    last_row   = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      set_text_color(phase_colors[phase]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        mode    = $urandom_range(0, 19);
        burst   = $urandom_range(4, 60);
        nl_odds = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(4, 16);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          c.char_code  = 8'($urandom);
          c.cell_color = 8'($urandom);
          c.col        = COL_W'($urandom);
          c.row        = ROW_W'($urandom);
          if (mode < 10) begin
            // Lines of text; with no newlines the cursor has to wrap on its own.
            c.action = ACT_PUT;
            if (nl_odds != 0 && $urandom_range(1, nl_odds) == 1)
              c.char_code = NEWLINE_CODE;
          end else if (mode < 16) begin
            c.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
            if (c.action == ACT_READ && $urandom_range(0, 1)) begin
              c.col = COL_W'(last_col);
              c.row = ROW_W'(last_row);
            end else begin
              c.col = COL_W'($urandom_range(0, SCR_COLS - 1));
              c.row = ROW_W'($urandom_range(0, SCR_ROWS - 1));
            end
            if (c.action == ACT_WRITE) begin
              last_col = c.col;
              last_row = c.row;
            end
          end else if (mode < 19) begin
            c.action = action_t'($urandom_range(0, 3));
          end else begin
            c.action    = ACT_PUT;
            c.char_code = NEWLINE_CODE;
          end
          if (c.action == ACT_CLEAR && clears_seen >= CLEAR_BUDGET)
            c.action = ACT_READ;
          if (c.action == ACT_PUT && int'(cursor_row_m) == SCR_ROWS - 1 &&
              (c.char_code == NEWLINE_CODE || int'(cursor_col_m) == SCR_COLS - 1) &&
              scrolls_seen >= SCROLL_BUDGET)
            c.action = ACT_READ;
          idling_on = (items_sent < PHASES * PHASE_ITEMS - CALM_TAIL);
          maybe_pause();
          issue(c, 1'b0, '0);
          sent++;
          items_sent++;
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
